[sv/rfo_pkg.sv]
// Shared types and constants for the rectangle fill and outline rasteriser.
// Holds command codes, status codes, register indexes and the controller state type.
// Has no dependencies of its own.
package rfo_pkg;

  localparam int OPCODE_W = 2;
  localparam int KIND_W   = 8;
  localparam int COORD_W  = 20;
  localparam int CHAR_W   = 8;
  localparam int RC_W     = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 10;
  localparam int M_TDATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LATCHED = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FILL    = 8'h52;
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 8'h72;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd1;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd1;
  localparam logic [CHAR_W-1:0]     BG_RESET     = 8'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_DONE
  } rfo_state_t;

endpackage

[sv/rect_fill_outline_rasterizer_core.sv]
// Rectangle fill and outline rasteriser on a character canvas held in one synchronous RAM.
// Depends on rfo_pkg for command codes, status codes and the controller state type.
// A clear sweeps MAX_DIM*MAX_DIM cells and a draw sweeps height*width cells; a read, an invalid
// draw or an unused command does no sweep before its result.
// Throughput is one command at a time; the single RAM write port sets the sweep rate of one
// cell per cycle. Reset (synchronous, rst high) clears the error flag and the registers to
// width 1, height 1, background 32; the canvas RAM is undefined until the first clear.
module rect_fill_outline_rasterizer_core #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rect_left, rect_top, rect_width, rect_height, paint_char, read_row, read_col
  input  logic [rfo_pkg::S_TDATA_W-1:0]     s_tdata,
  // opcode, rect_kind
  input  logic [rfo_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, cell_char, six zero bits
  output logic [rfo_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic [rfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rfo_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * DIM_W;
  localparam int DEPTH = 1 << AW;
  localparam int XW    = (DIM_W + FRAC_BITS + 2 > 22) ? (DIM_W + FRAC_BITS + 2) : 22;
  localparam logic signed [XW-1:0] FX_ONE = XW'(64'd1 << FRAC_BITS);
  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAX_DIM - 1);

  function automatic logic [15:0] dim_clamp(input logic [CFG_DATA_W-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    if (w == 16'd0) begin
      return 16'd1;
    end else if (w > 16'(MAX_DIM)) begin
      return 16'(MAX_DIM);
    end
    return w;
  endfunction

  // Input field unpacking.
  logic [OPCODE_W-1:0]       opcode;
  logic [KIND_W-1:0]         rect_kind;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_width;
  logic signed [COORD_W-1:0] rect_height;
  logic [CHAR_W-1:0]         paint_char;
  logic [RC_W-1:0]           read_row;
  logic [RC_W-1:0]           read_col;

  assign opcode      = s_tuser[1:0];
  assign rect_kind   = s_tuser[9:2];
  assign rect_left   = s_tdata[19:0];
  assign rect_top    = s_tdata[39:20];
  assign rect_width  = s_tdata[59:40];
  assign rect_height = s_tdata[79:60];
  assign paint_char  = s_tdata[87:80];
  assign read_row    = s_tdata[95:88];
  assign read_col    = s_tdata[103:96];

  // Registers.
  rfo_state_t state, state_next;
  logic                   err;
  logic [CFG_DATA_W-1:0]  canvas_width, canvas_height;
  logic [CHAR_W-1:0]      background_char;
  logic signed [XW-1:0]   x1, x2, x1p, x2m, y1, y2, y1p, y2m;
  logic                   fill;
  logic [CHAR_W-1:0]      pch;
  logic [DIM_W-1:0]       row, col, lim_row, lim_col;
  logic [STATUS_W-1:0]    res_status;
  logic [CHAR_W-1:0]      res_cell;
  logic                   rd_ok;
  logic [CHAR_W-1:0]      mem [DEPTH];
  logic [CHAR_W-1:0]      rd_data;

  // Combinational signals.
  logic                   accept;
  logic [15:0]            w_dim, h_dim;
  logic signed [XW-1:0]   in_x1, in_y1, in_x2, in_y2;
  logic                   rect_bad;
  logic                   rd_inside;
  logic [AW-1:0]          rd_addr;
  logic signed [XW-1:0]   px, py;
  logic                   paint;
  logic                   sweep_last;
  logic                   mem_we;
  logic                   sweep;
  logic                   out_load;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign w_dim    = dim_clamp(canvas_width);
  assign h_dim    = dim_clamp(canvas_height);

  assign in_x1 = XW'(rect_left);
  assign in_y1 = XW'(rect_top);
  assign in_x2 = in_x1 + XW'(rect_width);
  assign in_y2 = in_y1 + XW'(rect_height);
  assign rect_bad = (rect_width <= 0) || (rect_height <= 0) ||
                    ((rect_kind != KIND_FILL) && (rect_kind != KIND_OUTLINE));

  assign rd_inside = (16'(read_row) < h_dim) && (16'(read_col) < w_dim);
  assign rd_addr   = {DIM_W'(read_row), DIM_W'(read_col)};

  assign px = $signed(XW'(col) << FRAC_BITS);
  assign py = $signed(XW'(row) << FRAC_BITS);
  assign paint = (px >= x1) && (px <= x2) && (py >= y1) && (py <= y2) &&
                 (fill || (px < x1p) || (px > x2m) || (py < y1p) || (py > y2m));
  assign sweep_last = (row == lim_row) && (col == lim_col);
  assign out_load   = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_CLEAR: state_next = S_CLEAR;
            OP_DRAW:  state_next = (!err && !rect_bad) ? S_DRAW : S_DONE;
            OP_READ:  state_next = S_READ;
            OP_NOP:   state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR, S_DRAW: begin
        if (sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls per state.
  always_comb begin
    mem_we = 1'b0;
    sweep  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        sweep  = 1'b1;
      end
      S_DRAW: begin
        mem_we = paint;
        sweep  = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
        sweep  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RESET;
      canvas_height   <= HEIGHT_RESET;
      background_char <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  canvas_width    <= cfg_data;
        REG_HEIGHT: canvas_height   <= cfg_data;
        REG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (accept) begin
      if (opcode == OP_CLEAR) begin
        err <= 1'b0;
      end else if ((opcode == OP_DRAW) && !err && rect_bad) begin
        err <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1  <= in_x1;
      x2  <= in_x2;
      x1p <= in_x1 + FX_ONE;
      x2m <= in_x2 - FX_ONE;
      y1  <= in_y1;
      y2  <= in_y2;
      y1p <= in_y1 + FX_ONE;
      y2m <= in_y2 - FX_ONE;
      fill <= (rect_kind == KIND_FILL);
      pch  <= paint_char;
      row  <= '0;
      col  <= '0;
      rd_ok <= !err && rd_inside;
      res_cell <= '0;
      if (opcode == OP_CLEAR) begin
        lim_row <= DIM_LAST;
        lim_col <= DIM_LAST;
      end else begin
        lim_row <= DIM_W'(h_dim - 16'd1);
        lim_col <= DIM_W'(w_dim - 16'd1);
      end
      priority if (opcode == OP_CLEAR) begin
        res_status <= ST_OK;
      end else if (err) begin
        res_status <= ST_LATCHED;
      end else if ((opcode == OP_DRAW) && rect_bad) begin
        res_status <= ST_INVALID;
      end else begin
        res_status <= ST_OK;
      end
    end else begin
      if (sweep) begin
        if (col == lim_col) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (state == S_READ) begin
        res_cell <= rd_ok ? rd_data : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{row, col}] <= (state == S_CLEAR) ? background_char : pch;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_load) begin
      m_tdata <= {6'd0, res_cell, res_status};
    end
  end

endmodule

[sv/rfo_checker.sv]
// Port-level checks for the rectangle rasteriser core, attached to it by a bind statement.
// Depends on rfo_pkg for status codes and the output bus width.
module rfo_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rfo_pkg::M_TDATA_W-1:0] m_tdata
);
  import rfo_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while one is in progress");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_INVALID ||
                  m_tdata[1:0] == ST_LATCHED))
    else $error("undefined status code");

  a_cell_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[9:2] == 8'd0))
    else $error("cell byte non-zero with error status");

endmodule

bind rect_fill_outline_rasterizer_core rfo_checker u_rfo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
